### rtl/slm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slm_pkg: sorted list merge shared definitions
// Types, codes and sizes shared by the front queue, the merge engine and the
// top level of the posting-list merge block.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int unsigned LIST_DEPTH = 32;
  localparam int unsigned IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned LEN_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned ID_W       = 24;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned QPTR_W     = 1;
  localparam int unsigned QCNT_W     = 2;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  // register indexes
  localparam logic REG_MERGE_MODE = 1'b0;

  // merge modes
  localparam logic MODE_INTERSECT = 1'b0;
  localparam logic MODE_UNION     = 1'b1;

  typedef enum logic [1:0] {
    ACT_APPEND_A = 2'd0,
    ACT_APPEND_B = 2'd1,
    ACT_RUN      = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CMD_APPEND_A,
    CMD_APPEND_B,
    CMD_RUN
  } cmd_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    action_e          action;
    logic [ID_W-1:0]  doc_id;
  } in_req_t;

  typedef struct packed {
    logic [ID_W-1:0]  result_id;
    logic             is_last;
    logic             empty_set;
    logic             overflowed;
    logic [CNT_W-1:0] result_count;
  } out_rsp_t;

  typedef struct packed {
    cmd_op_e          op;
    logic [ID_W-1:0]  id;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage
`default_nettype wire

### rtl/slm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slm_front: request intake and command queue
// Accepts requests, turns each action into a command, drops unused codes and
// holds commands in a short queue until the merge engine takes them.
// ----------------------------------------------------------------------------
module slm_front (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  slm_pkg::in_req_t          in_data_i,
  output slm_pkg::q_head_t          head_o,
  input  wire                       pop_i
);

  slm_pkg::cmd_t                    q_mem_q [slm_pkg::Q_DEPTH];
  logic [slm_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [slm_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [slm_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                             full;
  logic                             accept;
  logic                             known;
  logic                             push;
  logic                             do_pop;
  slm_pkg::cmd_t                    cmd;

  assign full       = (cnt_q == slm_pkg::QCNT_W'(slm_pkg::Q_DEPTH));
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  always_comb begin
    known   = 1'b1;
    cmd.id  = in_data_i.doc_id;
    cmd.op  = slm_pkg::CMD_RUN;
    unique case (in_data_i.action)
      slm_pkg::ACT_APPEND_A: cmd.op = slm_pkg::CMD_APPEND_A;
      slm_pkg::ACT_APPEND_B: cmd.op = slm_pkg::CMD_APPEND_B;
      slm_pkg::ACT_RUN:      cmd.op = slm_pkg::CMD_RUN;
      default:               known  = 1'b0;
    endcase
  end

  assign push   = accept && known;
  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = push   ? wr_ptr_q + slm_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + slm_pkg::QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + slm_pkg::QCNT_W'(push) - slm_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = q_mem_q[rd_ptr_q];

endmodule
`default_nettype wire

### rtl/slm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slm_back: list storage and merge engine
// Appends ids to the two lists, then merges them in two walks: one counts
// the merged set, the next sends each id through the output register.
// ----------------------------------------------------------------------------
module slm_back (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       mode_i,
  input  slm_pkg::q_head_t          head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output slm_pkg::out_rsp_t         out_data_o
);

  localparam logic [slm_pkg::LEN_W-1:0] FULL_LEN = slm_pkg::LEN_W'(slm_pkg::LIST_DEPTH);

  slm_pkg::back_state_e             state_q, state_d;
  logic [slm_pkg::ID_W-1:0]         list_a_q [slm_pkg::LIST_DEPTH];
  logic [slm_pkg::ID_W-1:0]         list_b_q [slm_pkg::LIST_DEPTH];
  logic [slm_pkg::LEN_W-1:0]        len_a_q, len_b_q;
  logic [slm_pkg::LEN_W-1:0]        ia_q, ib_q;
  logic [slm_pkg::CNT_W-1:0]        cnt_q, emit_q;
  logic                             ovf_q;
  logic                             out_valid_q;
  slm_pkg::out_rsp_t                out_q, out_d;

  // step of the two-pointer walk
  logic                             a_has, b_has;
  logic [slm_pkg::ID_W-1:0]         a_val, b_val;
  logic                             step_emit, step_adv_a, step_adv_b, step_done;
  logic [slm_pkg::ID_W-1:0]         step_val;

  // controls
  logic                             out_free, out_load;
  logic                             wr_a, wr_b, set_ovf;
  logic                             walk_start, ptr_rst, adv_a, adv_b;
  logic                             cnt_inc, emit_inc, run_end, last_emit;

  assign a_has = (ia_q < len_a_q);
  assign b_has = (ib_q < len_b_q);
  assign a_val = list_a_q[ia_q[slm_pkg::IDX_W-1:0]];
  assign b_val = list_b_q[ib_q[slm_pkg::IDX_W-1:0]];

  always_comb begin
    step_emit  = 1'b0;
    step_adv_a = 1'b0;
    step_adv_b = 1'b0;
    step_done  = 1'b0;
    step_val   = a_val;
    if (a_has && b_has) begin
      if (a_val > b_val) begin
        step_emit  = (mode_i == slm_pkg::MODE_UNION);
        step_val   = b_val;
        step_adv_b = 1'b1;
      end else if (a_val < b_val) begin
        step_emit  = (mode_i == slm_pkg::MODE_UNION);
        step_adv_a = 1'b1;
      end else begin
        step_emit  = 1'b1;
        step_adv_a = 1'b1;
        step_adv_b = 1'b1;
      end
    end else if (mode_i == slm_pkg::MODE_INTERSECT) begin
      step_done = 1'b1;
    end else if (a_has) begin
      step_emit  = 1'b1;
      step_adv_a = 1'b1;
    end else if (b_has) begin
      step_emit  = 1'b1;
      step_val   = b_val;
      step_adv_b = 1'b1;
    end else begin
      step_done = 1'b1;
    end
  end

  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_emit = (emit_q + slm_pkg::CNT_W'(1) == cnt_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slm_pkg::ST_IDLE: begin
        if (head_i.valid && head_i.cmd.op == slm_pkg::CMD_RUN) begin
          state_d = slm_pkg::ST_COUNT;
        end
      end
      slm_pkg::ST_COUNT: begin
        if (step_done) begin
          state_d = slm_pkg::ST_EMIT;
        end
      end
      slm_pkg::ST_EMIT: begin
        if (out_free && (cnt_q == '0 || (step_emit && last_emit))) begin
          state_d = slm_pkg::ST_IDLE;
        end
      end
      default: state_d = slm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o      = 1'b0;
    wr_a       = 1'b0;
    wr_b       = 1'b0;
    set_ovf    = 1'b0;
    walk_start = 1'b0;
    ptr_rst    = 1'b0;
    adv_a      = 1'b0;
    adv_b      = 1'b0;
    cnt_inc    = 1'b0;
    emit_inc   = 1'b0;
    run_end    = 1'b0;
    out_load   = 1'b0;
    out_d.result_id    = step_val;
    out_d.is_last      = last_emit;
    out_d.empty_set    = 1'b0;
    out_d.overflowed   = ovf_q;
    out_d.result_count = cnt_q;
    unique case (state_q)
      slm_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          case (head_i.cmd.op)
            slm_pkg::CMD_APPEND_A: begin
              wr_a    = (len_a_q != FULL_LEN);
              set_ovf = (len_a_q == FULL_LEN);
            end
            slm_pkg::CMD_APPEND_B: begin
              wr_b    = (len_b_q != FULL_LEN);
              set_ovf = (len_b_q == FULL_LEN);
            end
            default: begin
              walk_start = 1'b1;
              ptr_rst    = 1'b1;
            end
          endcase
        end
      end
      slm_pkg::ST_COUNT: begin
        if (step_done) begin
          ptr_rst = 1'b1;
        end else begin
          adv_a   = step_adv_a;
          adv_b   = step_adv_b;
          cnt_inc = step_emit;
        end
      end
      slm_pkg::ST_EMIT: begin
        if (cnt_q == '0) begin
          if (out_free) begin
            out_load           = 1'b1;
            run_end            = 1'b1;
            out_d.result_id    = '0;
            out_d.is_last      = 1'b1;
            out_d.empty_set    = 1'b1;
          end
        end else if (!step_emit) begin
          adv_a = step_adv_a;
          adv_b = step_adv_b;
        end else if (out_free) begin
          adv_a    = step_adv_a;
          adv_b    = step_adv_b;
          out_load = 1'b1;
          emit_inc = 1'b1;
          run_end  = last_emit;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slm_pkg::ST_IDLE;
      len_a_q     <= '0;
      len_b_q     <= '0;
      ovf_q       <= 1'b0;
      ia_q        <= '0;
      ib_q        <= '0;
      cnt_q       <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (run_end) begin
        len_a_q <= '0;
        len_b_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        if (wr_a)    len_a_q <= len_a_q + slm_pkg::LEN_W'(1);
        if (wr_b)    len_b_q <= len_b_q + slm_pkg::LEN_W'(1);
        if (set_ovf) ovf_q   <= 1'b1;
      end
      if (ptr_rst) begin
        ia_q <= '0;
        ib_q <= '0;
      end else begin
        if (adv_a) ia_q <= ia_q + slm_pkg::LEN_W'(1);
        if (adv_b) ib_q <= ib_q + slm_pkg::LEN_W'(1);
      end
      if (walk_start) begin
        cnt_q  <= '0;
        emit_q <= '0;
      end else begin
        if (cnt_inc)  cnt_q  <= cnt_q + slm_pkg::CNT_W'(1);
        if (emit_inc) emit_q <= emit_q + slm_pkg::CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) list_a_q[len_a_q[slm_pkg::IDX_W-1:0]] <= head_i.cmd.id;
    if (wr_b) list_b_q[len_b_q[slm_pkg::IDX_W-1:0]] <= head_i.cmd.id;
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_a_q <= FULL_LEN) && (len_b_q <= FULL_LEN))
    else $error("list length beyond depth");

  a_emit_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == slm_pkg::ST_EMIT && cnt_q != '0) |-> (emit_q < cnt_q))
    else $error("emitted more results than counted");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == slm_pkg::ST_IDLE))
    else $error("command taken outside idle");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.is_last) |=> (state_q == slm_pkg::ST_IDLE && len_a_q == '0
      && len_b_q == '0 && !ovf_q))
    else $error("run did not end with its last result");
`endif

endmodule
`default_nettype wire

### rtl/sorted_id_list_set_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_id_list_set_merge: posting-list intersection and union engine
// Append requests are taken one per cycle sustained while no run is in progress.
// A run first walks both lists to count the merged set, then walks them again
// while the results drain through the output register.
// A two-entry command queue and an output register decouple the two sides.
// Reset clears lengths, overflow flag, queue and merge_mode; list contents
// stay undefined until written.
// ----------------------------------------------------------------------------
module sorted_id_list_set_merge (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  slm_pkg::in_req_t              in_data_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output slm_pkg::out_rsp_t             out_data_o,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire [slm_pkg::PADDR_W-1:0]    paddr,
  input  wire [slm_pkg::PDATA_W-1:0]    pwdata,
  output logic [slm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic             mode_q;
  logic             reg_hit;
  slm_pkg::q_head_t head;
  logic             pop;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == slm_pkg::REG_MERGE_MODE) && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= slm_pkg::MODE_INTERSECT;
    end else if (psel && penable && pwrite && reg_hit) begin
      mode_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata[0] = mode_q;
    end
  end

  slm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  slm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
